@@ rtl/core/b64c_pkg.sv @@
// Shared types, constants and character mapping functions for the base64 codec.
package b64c_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam logic       DIR_ENCODE = 1'b0;
    localparam logic       DIR_DECODE = 1'b1;
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [7:0] data_in;
        logic       end_of_stream;
    } b64c_in_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       final_result;
        logic       bad_input;
    } b64c_out_t;

    // One request's worth of results, handed from the front to the back.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            fin;
        logic            bad;
    } b64c_grp_t;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            enc_char = w + 8'd65;
        end else if (v < 6'd52) begin
            enc_char = w + 8'd71;
        end else if (v < 6'd62) begin
            enc_char = w - 8'd4;
        end else if (v == 6'd62) begin
            enc_char = 8'd43;
        end else begin
            enc_char = 8'd47;
        end
    endfunction

    // Bit 6 set means the character is not in the alphabet.
    function automatic logic [6:0] six_of(input logic [7:0] ch);
        if (ch >= 8'd65 && ch <= 8'd90) begin
            six_of = 7'(ch - 8'd65);
        end else if (ch >= 8'd97 && ch <= 8'd122) begin
            six_of = 7'(ch - 8'd71);
        end else if (ch >= 8'd48 && ch <= 8'd57) begin
            six_of = 7'(ch + 8'd4);
        end else if (ch == 8'd43) begin
            six_of = 7'd62;
        end else if (ch == 8'd47) begin
            six_of = 7'd63;
        end else begin
            six_of = 7'd64;
        end
    endfunction

endpackage

@@ rtl/core/b64c_front.sv @@
// Front end: accepts items, keeps group state, builds groups on group end, eos or error.
module b64c_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_direction,
    input  logic               s_valid,
    output logic               s_ready,
    input  b64c_pkg::b64c_in_t s_data,
    input  logic               q_full,
    output logic               q_push,
    output b64c_pkg::b64c_grp_t q_data
);
    import b64c_pkg::*;

    logic        dir_reg, dir_next;
    logic [23:0] acc_reg, acc_next;
    logic [1:0]  pos_reg, pos_next;
    logic [1:0]  pad_reg, pad_next;
    logic        failed_reg, failed_next;

    logic        take;
    logic        emit;
    b64c_grp_t   grp;
    logic [23:0] enc_sh;
    logic [23:0] enc_v;
    logic [23:0] dec_sh;
    logic [6:0]  six;
    logic        is_pad;
    logic        err;
    logic [1:0]  pad_inc;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign take      = s_valid && s_ready;
    assign q_push    = take && emit;
    assign q_data    = grp;

    assign enc_sh  = {acc_reg[15:0], s_data.data_in};
    assign six     = six_of(s_data.data_in);
    assign is_pad  = (s_data.data_in == PAD_CHAR);
    assign dec_sh  = {acc_reg[17:0], (is_pad ? 6'd0 : six[5:0])};
    assign pad_inc = pad_reg + {1'b0, is_pad};

    always_comb begin
        dir_next    = dir_reg;
        acc_next    = acc_reg;
        pos_next    = pos_reg;
        pad_next    = pad_reg;
        failed_next = failed_reg;
        emit        = 1'b0;
        err         = 1'b0;
        enc_v       = enc_sh;
        grp.bytes   = '0;
        grp.last_idx = 2'd3;
        grp.fin     = s_data.end_of_stream;
        grp.bad     = 1'b0;

        if (dir_reg == DIR_ENCODE) begin
            if (pos_reg == 2'd2) begin
                emit     = 1'b1;
                acc_next = '0;
                pos_next = '0;
            end else if (s_data.end_of_stream) begin
                emit  = 1'b1;
                enc_v = (pos_reg == 2'd0) ? {enc_sh[7:0], 16'd0} : {enc_sh[15:0], 8'd0};
            end else begin
                acc_next = enc_sh;
                pos_next = pos_reg + 2'd1;
            end
            grp.bytes[0] = enc_char(enc_v[23:18]);
            grp.bytes[1] = enc_char(enc_v[17:12]);
            grp.bytes[2] = (pos_reg == 2'd0 && s_data.end_of_stream) ? PAD_CHAR
                                                                      : enc_char(enc_v[11:6]);
            grp.bytes[3] = (pos_reg == 2'd2) ? enc_char(enc_v[5:0]) : PAD_CHAR;
        end else if (!failed_reg) begin
            if (!is_pad && six[6]) begin
                err = 1'b1;
            end
            if (is_pad && pos_reg < 2'd2) begin
                err = 1'b1;
            end
            if (!is_pad && pad_reg != 2'd0) begin
                err = 1'b1;
            end
            grp.bytes[0] = dec_sh[23:16];
            grp.bytes[1] = dec_sh[15:8];
            grp.bytes[2] = dec_sh[7:0];
            grp.last_idx = (pad_inc >= 2'd2) ? 2'd0 : ((pad_inc == 2'd1) ? 2'd1 : 2'd2);
            if (!err) begin
                pad_next = pad_inc;
                if (pos_reg == 2'd3) begin
                    emit     = 1'b1;
                    acc_next = '0;
                    pos_next = '0;
                end else if (s_data.end_of_stream) begin
                    err = 1'b1;
                end else begin
                    acc_next = dec_sh;
                    pos_next = pos_reg + 2'd1;
                end
            end
            if (err) begin
                // A single error result, then silence until the stream ends.
                emit         = 1'b1;
                grp.bytes    = '0;
                grp.last_idx = 2'd0;
                grp.bad      = 1'b1;
                acc_next     = '0;
                pos_next     = '0;
                pad_next     = '0;
                failed_next  = 1'b1;
            end
        end

        if (!take) begin
            acc_next    = acc_reg;
            pos_next    = pos_reg;
            pad_next    = pad_reg;
            failed_next = failed_reg;
        end else if (s_data.end_of_stream) begin
            acc_next    = '0;
            pos_next    = '0;
            pad_next    = '0;
            failed_next = 1'b0;
        end

        if (cfg_valid) begin
            dir_next    = cfg_direction;
            acc_next    = '0;
            pos_next    = '0;
            pad_next    = '0;
            failed_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg    <= DIR_ENCODE;
            acc_reg    <= '0;
            pos_reg    <= '0;
            pad_reg    <= '0;
            failed_reg <= 1'b0;
        end else begin
            dir_reg    <= dir_next;
            acc_reg    <= acc_next;
            pos_reg    <= pos_next;
            pad_reg    <= pad_next;
            failed_reg <= failed_next;
        end
    end

endmodule

@@ rtl/core/b64c_queue.sv @@
// Small FIFO of result groups between the front and the back.
module b64c_queue #(
    parameter int unsigned DEPTH = b64c_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  b64c_pkg::b64c_grp_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output b64c_pkg::b64c_grp_t pop_data
);
    import b64c_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    b64c_grp_t       mem_reg [DEPTH];
    logic [PW-1:0]   wptr_reg, wptr_next;
    logic [PW-1:0]   rptr_reg, rptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_push;
    logic            do_pop;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/b64c_back.sv @@
// Back end: holds one result group and sends its results one per request.
module b64c_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_not_empty,
    input  b64c_pkg::b64c_grp_t  q_data,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output b64c_pkg::b64c_out_t  m_data
);
    import b64c_pkg::*;

    b64c_grp_t  cur_reg, cur_next;
    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       at_last;
    logic       done;
    logic       load;

    assign at_last = (idx_reg == cur_reg.last_idx);
    assign done    = valid_reg && m_ready && at_last;
    assign load    = !valid_reg || done;
    assign q_pop   = load && q_not_empty;

    assign m_valid             = valid_reg;
    assign m_data.data_out     = cur_reg.bytes[idx_reg];
    assign m_data.final_result = cur_reg.fin && at_last;
    assign m_data.bad_input    = cur_reg.bad;

    always_comb begin
        cur_next   = cur_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            cur_next   = q_data;
            valid_next = q_not_empty;
            idx_next   = '0;
        end else if (m_ready) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

endmodule

@@ rtl/core/base64_codec.sv @@
// Top level of the streaming base64 codec: front end, group queue and result serializer.
// The first result of a group passes through the group queue and the serializer register
// on its way to the result port, and waits while earlier results are not yet taken.
// Throughput while the queue has room and m_ready is high: one input item and one result
// per cycle; encoding is port-bound at four results per three bytes, decoding is not.
// Reset (aresetn low, synchronous) selects encode, clears stream state, empties the queue.
module base64_codec #(
    parameter int unsigned QUEUE_DEPTH = b64c_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_direction,
    input  logic                s_valid,
    output logic                s_ready,
    input  b64c_pkg::b64c_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output b64c_pkg::b64c_out_t m_data
);
    import b64c_pkg::*;

    // The queue is emptied by reset as well; no memory needs clearing.
    logic      q_full;
    logic      q_push;
    logic      q_pop;
    logic      q_not_empty;
    b64c_grp_t q_in;
    b64c_grp_t q_out;

    b64c_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_direction (cfg_direction),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_in)
    );

    b64c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    b64c_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

@@ sim/base64_codec_tb.sv @@
// Self-checking testbench for the streaming base64 codec, with randomized traffic and stalls.
module base64_codec_tb;
    import b64c_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 250;
    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_direction = DIR_ENCODE;
    logic      s_valid = 1'b0;
    logic      s_ready;
    b64c_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    b64c_out_t m_data;

    base64_codec DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_direction(cfg_direction),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

    always #5 aclk = ~aclk;

    // Codec state as seen by the predictor.
    logic        dir_sel = DIR_ENCODE;
    logic [23:0] acc_bits = '0;
    logic [1:0]  grp_pos = '0;
    logic [1:0]  pad_seen = '0;
    logic        stream_dead = 1'b0;

    b64c_in_t  items_to_send[$];
    b64c_out_t outputs_due[$];
    int        items_left = 0;
    int        items_queued = 0;
    int        mismatches = 0;

    // Sender and receiver pacing.
    logic offer;
    logic take;
    int   send_gap = 0;
    int   send_calm = 0;
    int   recv_gap = 0;
    int   recv_calm = 0;
    int   hold_left = 0;
    logic want_long_hold = 1'b0;
    logic long_hold_done = 1'b0;
    int   idle_cycles = 0;
    b64c_out_t want;

    function automatic logic [7:0] b64_char(input int idx);
        return B64_ALPHABET[8*(63-idx) +: 8];
    endfunction

    function automatic int sextet_of(input logic [7:0] ch);
        for (int i = 0; i < 64; i++) begin
            if (b64_char(i) == ch) return i;
        end
        return -1;
    endfunction

    function automatic logic [7:0] stray_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == PAD_CHAR || sextet_of(c) >= 0);
        return c;
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic clear_stream_state();
        acc_bits = '0;
        grp_pos = '0;
        pad_seen = '0;
        stream_dead = 1'b0;
    endtask

    // Works out the results that one accepted request causes.
    task automatic codec_step(input b64c_in_t item);
        b64c_out_t produced[4];
        int        n;
        int        pos;
        int        sx;
        logic      is_pad;
        logic      err;
        logic [23:0] v;
        n = 0;
        pos = grp_pos;
        if (dir_sel == DIR_ENCODE) begin
            acc_bits = {acc_bits[15:0], item.data_in};
            pos++;
            if (pos == 3) begin
                for (int k = 0; k < 4; k++)
                    produced[n++] = '{b64_char(acc_bits[18-6*k +: 6]), 1'b0, 1'b0};
                pos = 0;
                acc_bits = '0;
            end else if (item.end_of_stream) begin
                v = (pos == 1) ? {acc_bits[7:0], 16'h0} : {acc_bits[15:0], 8'h0};
                produced[n++] = '{b64_char(v[23:18]), 1'b0, 1'b0};
                produced[n++] = '{b64_char(v[17:12]), 1'b0, 1'b0};
                produced[n++] = '{(pos == 2) ? b64_char(v[11:6]) : PAD_CHAR, 1'b0, 1'b0};
                produced[n++] = '{PAD_CHAR, 1'b0, 1'b0};
            end
            grp_pos = 2'(pos);
        end else if (!stream_dead) begin
            is_pad = (item.data_in == PAD_CHAR);
            sx = sextet_of(item.data_in);
            err = 1'b0;
            if (!is_pad && sx < 0) err = 1'b1;
            if (is_pad && pos < 2) err = 1'b1;
            if (!is_pad && pad_seen != 0) err = 1'b1;
            if (!err) begin
                acc_bits = {acc_bits[17:0], is_pad ? 6'd0 : 6'(sx)};
                if (is_pad) pad_seen = pad_seen + 2'd1;
                pos++;
                if (pos == 4) begin
                    produced[n++] = '{acc_bits[23:16], 1'b0, 1'b0};
                    if (pad_seen < 2) produced[n++] = '{acc_bits[15:8], 1'b0, 1'b0};
                    if (pad_seen < 1) produced[n++] = '{acc_bits[7:0], 1'b0, 1'b0};
                    pos = 0;
                    acc_bits = '0;
                end else if (item.end_of_stream) begin
                    // A stream may not end inside a group.
                    err = 1'b1;
                end
            end
            if (err) begin
                n = 0;
                produced[n++] = '{8'h00, item.end_of_stream, 1'b1};
                acc_bits = '0;
                pos = 0;
                pad_seen = '0;
                stream_dead = 1'b1;
            end
            grp_pos = 2'(pos);
        end
        if (item.end_of_stream) begin
            if (n > 0) produced[n-1].final_result = 1'b1;
            clear_stream_state();
        end
        for (int k = 0; k < n; k++) outputs_due.push_back(produced[k]);
    endtask

    task automatic queue_item(input logic [7:0] d, input logic eos);
        items_to_send.push_back('{d, eos});
        items_left++;
        items_queued++;
    endtask

    task automatic queue_chars(input string s, input logic close);
        for (int i = 0; i < s.len(); i++) queue_item(s[i], close && i == s.len() - 1);
    endtask

    task automatic queue_text(ref logic [7:0] text[$]);
        for (int i = 0; i < text.size(); i++) queue_item(text[i], i == text.size() - 1);
    endtask

    task automatic encode_stream();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
        for (int i = 0; i < len; i++) queue_item(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    // Well-formed text with random content, optionally damaged in one way.
    task automatic decode_stream(input logic broken);
        logic [7:0] text[$];
        int groups;
        int tail;
        int g;
        groups = $urandom_range(0, 3);
        tail = $urandom_range(0, 2);
        if (groups == 0 && tail == 0) groups = 1;
        for (int i = 0; i < 4 * groups; i++) text.push_back(b64_char($urandom_range(0, 63)));
        for (int i = 0; i < 4 - tail && tail != 0; i++)
            text.push_back(b64_char($urandom_range(0, 63)));
        for (int i = 0; i < tail; i++) text.push_back(PAD_CHAR);
        if (broken) begin
            case ($urandom_range(0, 3))
                0: text[$urandom_range(0, text.size() - 1)] = stray_char();
                1: begin
                    g = $urandom_range(0, text.size() / 4 - 1);
                    text[4 * g + $urandom_range(0, 1)] = PAD_CHAR;
                end
                2: begin
                    g = $urandom_range(1, 3);
                    repeat (g) text.delete(text.size() - 1);
                end
                default: begin
                    if (text[text.size() - 1] == PAD_CHAR) begin
                        g = $urandom_range(1, 4);
                        repeat (g) text.push_back(b64_char($urandom_range(0, 63)));
                    end else begin
                        text[text.size() - 2] = PAD_CHAR;
                    end
                end
            endcase
        end
        queue_text(text);
    endtask

    task automatic noise_stream();
        int len;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) queue_item(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    // Waits until every request is taken and every result has come back.
    task automatic drain();
        while (items_left != 0 || outputs_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_direction(input logic dir);
        @(posedge aclk);
        cfg_direction <= dir;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        dir_sel = dir;
        clear_stream_state();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            offer = s_valid;
            if (s_valid && s_ready) begin
                codec_step(s_data);
                items_left--;
                offer = 1'b0;
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (items_to_send.size() != 0) begin
                    s_data <= items_to_send.pop_front();
                    offer = 1'b1;
                    if (send_calm > 0) send_calm--;
                    else if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(20, 80);
                    else send_gap = gap_length();
                end
            end
            s_valid <= offer;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (outputs_due.size() == 0) begin
                    $display("%0t: unexpected result data=%h fin=%b bad=%b", $time,
                             m_data.data_out, m_data.final_result, m_data.bad_input);
                    mismatches++;
                end else begin
                    want = outputs_due.pop_front();
                    if (m_data.data_out !== want.data_out ||
                        m_data.final_result !== want.final_result ||
                        m_data.bad_input !== want.bad_input) begin
                        $display("%0t: expected data=%h fin=%b bad=%b, got data=%h fin=%b bad=%b",
                                 $time, want.data_out, want.final_result, want.bad_input,
                                 m_data.data_out, m_data.final_result, m_data.bad_input);
                        mismatches++;
                    end
                end
            end
            // One long hold-off lets the block fill up and push back on its input.
            if (want_long_hold && !long_hold_done && m_valid) begin
                hold_left = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                take = 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                take = 1'b0;
            end else begin
                take = 1'b1;
                if (recv_calm > 0) recv_calm--;
                else if ($urandom_range(0, 39) == 0) recv_calm = $urandom_range(20, 80);
                else recv_gap = gap_length();
            end
            m_ready <= take;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Encode: full group at the end, one and two leftover bytes, then a
        // partial group that the next direction write throws away.
        write_direction(DIR_ENCODE);
        queue_item(8'h00, 1'b0);
        queue_item(8'hFF, 1'b0);
        queue_item(8'h80, 1'b1);
        queue_item(8'hFF, 1'b1);
        queue_item(8'h01, 1'b0);
        queue_item(8'hFE, 1'b1);
        queue_item(8'h7F, 1'b0);
        queue_item(8'hC3, 1'b0);
        drain();

        // Decode: alphabet extremes, the two-pad form, a character after a pad,
        // a stray character, a pad too early, a short stream and a partial group.
        write_direction(DIR_DECODE);
        queue_chars("Az+/", 1'b1);
        queue_chars("QQ==", 1'b1);
        queue_chars("QU=A", 1'b1);
        queue_chars("*", 1'b1);
        queue_chars("A=B", 1'b1);
        queue_chars("QUJ", 1'b1);
        queue_chars("QU", 1'b0);
        drain();

        write_direction(DIR_ENCODE);
        want_long_hold = 1'b1;
        items_queued = 0;
        while (items_queued < 120) encode_stream();
        drain();

        write_direction(DIR_DECODE);
        items_queued = 0;
        while (items_queued < 160) begin
            case ($urandom_range(0, 19))
                0, 1, 2:  decode_stream(1'b1);
                3, 4:     noise_stream();
                default:  decode_stream(1'b0);
            endcase
        end
        drain();

        write_direction(DIR_ENCODE);
        items_queued = 0;
        while (items_queued < 50) encode_stream();
        drain();

        write_direction(DIR_DECODE);
        items_queued = 0;
        while (items_queued < 60) begin
            case ($urandom_range(0, 9))
                0, 1:    decode_stream(1'b1);
                2, 3:    noise_stream();
                default: decode_stream(1'b0);
            endcase
        end
        drain();

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/b64c_pkg.sv
rtl/core/b64c_front.sv
rtl/core/b64c_queue.sv
rtl/core/b64c_back.sv
rtl/core/base64_codec.sv
sim/base64_codec_tb.sv
